// ===== sv/plc_pkg.sv =====
// Shared types, constants and tables for the proximity lid controller.
`default_nettype none

package plc_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned LedW    = 8;
  localparam int unsigned StampW  = 32;
  localparam int unsigned EchoW   = 16;
  localparam int unsigned AdcW    = 10;
  localparam int unsigned ServoW  = 7;
  localparam int unsigned DistW   = 11;
  localparam int unsigned PctW    = 7;
  localparam int unsigned OpenW   = 9;
  localparam int unsigned MsW     = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Widths of the two serial dividers.
  localparam int unsigned EchoDenW = 6;
  localparam int unsigned FillNumW = 14;
  localparam int unsigned FillDenW = 13;

  localparam logic [EchoDenW-1:0] EchoPerCm   = EchoDenW'(58);
  localparam logic [FillNumW-1:0] FillScale   = FillNumW'(13312);
  localparam logic [DistW-1:0]    NoEchoCm    = DistW'(400);
  localparam logic [ServoW-1:0]   ServoClosed = ServoW'(120);
  localparam logic [ServoW-1:0]   ServoOpen   = ServoW'(0);
  localparam logic [4:0]          FillClamp   = 5'd26;

  localparam logic [OpenW-1:0] OpenDistReset  = OpenW'(20);
  localparam logic [MsW-1:0]   IntervalReset  = MsW'(1000);
  localparam logic [MsW-1:0]   SettleReset    = MsW'(1500);
  localparam logic [LedW-1:0]  LockLevelReset = LedW'(255);

  typedef enum logic [ModeW-1:0] {
    MODE_PASS   = 2'd0,
    MODE_LED    = 2'd1,
    MODE_REPORT = 2'd2,
    MODE_SPARE  = 2'd3
  } plc_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OPEN_DIST = 2'd0,
    REG_INTERVAL  = 2'd1,
    REG_SETTLE    = 2'd2,
    REG_LOCK_LVL  = 2'd3
  } plc_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } plc_state_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [LedW-1:0]   brightness;
    logic [StampW-1:0] now_ms;
    logic [EchoW-1:0]  echo_us;
    logic [AdcW-1:0]   ir_adc;
  } plc_in_t;

  typedef struct packed {
    logic              lid_is_open;
    logic [ServoW-1:0] servo_angle;
    logic [LedW-1:0]   led_level;
    logic              lock_flag;
    logic              measured;
    logic [DistW-1:0]  distance_cm;
    logic              report_valid;
    logic [PctW-1:0]   fullness_pct;
  } plc_out_t;

  // Fill percentage for a clamped IR distance d of 0..26: (26 - d) * 100 / 26.
  function automatic logic [PctW-1:0] level_of(input logic [4:0] d);
    logic [PctW-1:0] lvl;
    case (d)
      5'd0:    lvl = 7'd100;
      5'd1:    lvl = 7'd96;
      5'd2:    lvl = 7'd92;
      5'd3:    lvl = 7'd88;
      5'd4:    lvl = 7'd84;
      5'd5:    lvl = 7'd80;
      5'd6:    lvl = 7'd76;
      5'd7:    lvl = 7'd73;
      5'd8:    lvl = 7'd69;
      5'd9:    lvl = 7'd65;
      5'd10:   lvl = 7'd61;
      5'd11:   lvl = 7'd57;
      5'd12:   lvl = 7'd53;
      5'd13:   lvl = 7'd50;
      5'd14:   lvl = 7'd46;
      5'd15:   lvl = 7'd42;
      5'd16:   lvl = 7'd38;
      5'd17:   lvl = 7'd34;
      5'd18:   lvl = 7'd30;
      5'd19:   lvl = 7'd26;
      5'd20:   lvl = 7'd23;
      5'd21:   lvl = 7'd19;
      5'd22:   lvl = 7'd15;
      5'd23:   lvl = 7'd11;
      5'd24:   lvl = 7'd7;
      5'd25:   lvl = 7'd3;
      default: lvl = 7'd0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ===== sv/proximity_lid_controller.sv =====
// Top level of the proximity lid controller: command handling, timing and lid decision.
`default_nettype none

// Each input transfer is one pass of the control loop; each one yields exactly one
// output transfer carrying the lid, LED, lock, distance and fill level status.
// Channels: in_valid_i / in_stall_o with payload in_data_i, and out_valid_o /
// out_stall_i with payload out_data_o. A transfer happens at a rising edge where
// valid is high and stall is low. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i, one register per cycle; the user must write them
// only while the block is idle, as the block itself does not enforce this. The
// result goes to the output register once both dividers are done; the echo divider,
// which produces one quotient bit per cycle over its sixteen bit dividend, finishes
// last, the fill level divider alongside it. Only one item is in flight at a time.
// The input is stalled from acceptance until the result is written out, so a new
// item may be taken while the previous result still waits at the output.
// When the receiver stalls, the result stays in the output register unchanged and
// a finished item waits, holding its state update, until the register is free.
// Reset clears the lid, lock, stamps, fill level, LED and distance state to zero and
// returns the configuration registers to their default values.

module proximity_lid_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire plc_pkg::plc_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output plc_pkg::plc_out_t                  out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [plc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [plc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // Configuration registers.
  logic [plc_pkg::OpenW-1:0] open_dist_q;
  logic [plc_pkg::MsW-1:0]   interval_q;
  logic [plc_pkg::MsW-1:0]   settle_q;
  logic [plc_pkg::LedW-1:0]  lock_lvl_q;

  // Loop state.
  logic                        locked_q, locked_d;
  logic                        open_q, open_d;
  logic [plc_pkg::StampW-1:0]  close_stamp_q, close_stamp_d;
  logic [plc_pkg::StampW-1:0]  meas_stamp_q, meas_stamp_d;
  logic [plc_pkg::PctW-1:0]    fill_q, fill_d;
  logic [plc_pkg::LedW-1:0]    led_q, led_d;
  logic [plc_pkg::DistW-1:0]   dist_q, dist_d;

  // Captured item and the time checks made on acceptance.
  plc_pkg::plc_in_t item_q;
  logic             meas_due_q;
  logic             fill_due_q;

  plc_pkg::plc_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  plc_pkg::plc_out_t   out_data_q, out_data_d;

  logic                           accept;
  logic                           commit;
  logic [plc_pkg::StampW-1:0]     meas_limit;
  logic [plc_pkg::StampW-1:0]     fill_limit;
  logic [plc_pkg::FillDenW-1:0]   adc_x5;
  logic                           echo_busy;
  logic                           fill_busy;
  logic [plc_pkg::EchoW-1:0]      echo_quo;
  logic [plc_pkg::FillNumW-1:0]   fill_quo;
  logic [plc_pkg::DistW-1:0]      new_dist;
  logic [4:0]                     ir_dist;

  assign accept = in_valid_i && !in_stall_o;

  // Both time comparisons wrap modulo 2^32, exactly as the stamps do.
  assign meas_limit = meas_stamp_q + {{(plc_pkg::StampW - plc_pkg::MsW){1'b0}}, interval_q};
  assign fill_limit = close_stamp_q + {{(plc_pkg::StampW - plc_pkg::MsW){1'b0}}, settle_q};

  // Five times the ADC sample as a shift and an add.
  assign adc_x5 = {1'b0, in_data_i.ir_adc, 2'b00}
                + {3'b000, in_data_i.ir_adc};

  plc_sdiv #(
    .NumW (plc_pkg::EchoW),
    .DenW (plc_pkg::EchoDenW)
  ) u_echo_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (in_data_i.echo_us),
    .den_i   (plc_pkg::EchoPerCm),
    .busy_o  (echo_busy),
    .quo_o   (echo_quo)
  );

  // A zero sample divides by zero and yields all ones, which clamps to the
  // same empty level that an absent reading gives.
  plc_sdiv #(
    .NumW (plc_pkg::FillNumW),
    .DenW (plc_pkg::FillDenW)
  ) u_fill_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (plc_pkg::FillScale),
    .den_i   (adc_x5),
    .busy_o  (fill_busy),
    .quo_o   (fill_quo)
  );

  // Sequencer: accept an item, wait for both dividers, then write the result
  // once the output register is free.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    commit     = 1'b0;
    case (state_q)
      plc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = plc_pkg::ST_RUN;
        end
      end
      plc_pkg::ST_RUN: begin
        if (!echo_busy && !fill_busy && (!out_valid_q || !out_stall_i)) begin
          commit  = 1'b1;
          state_d = plc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plc_pkg::ST_IDLE;
      end
    endcase
  end

  // State update for one item: the command first, then the measurement.
  always_comb begin
    locked_d      = locked_q;
    led_d         = led_q;
    fill_d        = fill_q;
    open_d        = open_q;
    close_stamp_d = close_stamp_q;
    meas_stamp_d  = meas_stamp_q;
    dist_d        = dist_q;

    // The echo quotient is at most 1129, so eleven bits hold it.
    new_dist = (echo_quo == '0) ? plc_pkg::NoEchoCm : echo_quo[plc_pkg::DistW-1:0];
    ir_dist  = (fill_quo > {{(plc_pkg::FillNumW - 5){1'b0}}, plc_pkg::FillClamp})
             ? plc_pkg::FillClamp : fill_quo[4:0];

    case (plc_pkg::plc_mode_e'(item_q.mode))
      plc_pkg::MODE_LED: begin
        locked_d = item_q.brightness == lock_lvl_q;
        led_d    = item_q.brightness;
      end
      plc_pkg::MODE_REPORT: begin
        if (fill_due_q) begin
          fill_d = plc_pkg::level_of(ir_dist);
        end
      end
      default: begin
      end
    endcase

    if (meas_due_q) begin
      meas_stamp_d = item_q.now_ms;
      dist_d       = new_dist;
      if (new_dist < {2'b00, open_dist_q} && !locked_d) begin
        open_d = 1'b1;
      end else begin
        if (open_q) begin
          close_stamp_d = item_q.now_ms;
        end
        open_d = 1'b0;
      end
    end

    out_data_d.lid_is_open  = open_d;
    out_data_d.servo_angle  = open_d ? plc_pkg::ServoOpen : plc_pkg::ServoClosed;
    out_data_d.led_level    = led_d;
    out_data_d.lock_flag    = locked_d;
    out_data_d.measured     = meas_due_q;
    out_data_d.distance_cm  = dist_d;
    out_data_d.report_valid = item_q.mode == plc_pkg::MODE_REPORT;
    out_data_d.fullness_pct = fill_d;

    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= plc_pkg::ST_IDLE;
      out_valid_q   <= 1'b0;
      locked_q      <= 1'b0;
      open_q        <= 1'b0;
      close_stamp_q <= '0;
      meas_stamp_q  <= '0;
      fill_q        <= '0;
      led_q         <= '0;
      dist_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        locked_q      <= locked_d;
        open_q        <= open_d;
        close_stamp_q <= close_stamp_d;
        meas_stamp_q  <= meas_stamp_d;
        fill_q        <= fill_d;
        led_q         <= led_d;
        dist_q        <= dist_d;
      end
    end
  end

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_dist_q <= plc_pkg::OpenDistReset;
      interval_q  <= plc_pkg::IntervalReset;
      settle_q    <= plc_pkg::SettleReset;
      lock_lvl_q  <= plc_pkg::LockLevelReset;
    end else if (cfg_we_i) begin
      case (plc_pkg::plc_reg_e'(cfg_idx_i))
        plc_pkg::REG_OPEN_DIST: open_dist_q <= cfg_wdata_i[plc_pkg::OpenW-1:0];
        plc_pkg::REG_INTERVAL:  interval_q  <= cfg_wdata_i[plc_pkg::MsW-1:0];
        plc_pkg::REG_SETTLE:    settle_q    <= cfg_wdata_i[plc_pkg::MsW-1:0];
        plc_pkg::REG_LOCK_LVL:  lock_lvl_q  <= cfg_wdata_i[plc_pkg::LedW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The item and its time checks are captured on acceptance; the state that
  // they read cannot change before the item is committed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_data_i;
      meas_due_q <= in_data_i.now_ms > meas_limit;
      fill_due_q <= !open_q && (in_data_i.now_ms > fill_limit);
    end
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/plc_sdiv.sv =====
// Restoring divider that produces one quotient bit per clock cycle.
`default_nettype none

module plc_sdiv #(
  parameter int unsigned NumW = 16,
  parameter int unsigned DenW = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic      [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] sh_q, sh_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            fits;

  // The shift register holds the remaining dividend bits at the top and
  // collects quotient bits at the bottom.
  always_comb begin
    trial = {rem_q, sh_q[NumW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    sh_d  = sh_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CntW'(NumW);
      sh_d  = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      sh_d  = {sh_q[NumW-2:0], fits};
      rem_d = fits ? diff[DenW-1:0] : trial[DenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = sh_q;

endmodule

`default_nettype wire

// ===== sv/plc_checker.sv =====
// Port-level checks for the proximity lid controller and their binding.
`default_nettype none

module plc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire plc_pkg::plc_out_t out_data_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Servo command agrees with the lid state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.lid_is_open
                     ? (out_data_o.servo_angle == plc_pkg::ServoOpen)
                     : (out_data_o.servo_angle == plc_pkg::ServoClosed)))
    else $error("servo angle disagrees with lid state");

  // Only one item is in flight: the input stalls right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while one is in flight");

endmodule

bind proximity_lid_controller plc_checker u_plc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/proximity_lid_controller_tb.sv =====
// Self-checking testbench for the proximity lid controller.
`timescale 1ns / 1ps

module proximity_lid_controller_tb;

  // Quiet cycles (no transfer on either channel) before the run is abandoned. The
  // longest legitimate quiet stretch is the receiver hold-off plus one item's latency.
  localparam int WatchdogLimit = 2000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HoldCycles    = 300;
  // Cycles allowed after the last expected status.
  localparam int DrainCycles   = 40;
  localparam int ItemsPerPhase = 80;
  localparam int MaxReported   = 10;

  logic                         clk_i     = 1'b0;
  logic                         rst_ni    = 1'b0;
  logic                         in_valid  = 1'b0;
  plc_pkg::plc_in_t             in_data   = '0;
  logic                         out_stall = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [plc_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [plc_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  plc_pkg::plc_out_t            out_data_o;

  // Idling percentages for the sender and receiver, and the hold-off request tag.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_tag     = 0;

  // Predicted lid controller: configuration copy and loop state.
  logic [plc_pkg::OpenW-1:0]  cfg_open_cm;
  logic [plc_pkg::MsW-1:0]    cfg_interval_ms;
  logic [plc_pkg::MsW-1:0]    cfg_settle_ms;
  logic [plc_pkg::LedW-1:0]   cfg_lock_level;
  logic                       lid_locked;
  logic                       open_now;
  logic [plc_pkg::StampW-1:0] closed_at_ms;
  logic [plc_pkg::StampW-1:0] measured_at_ms;
  logic [plc_pkg::PctW-1:0]   fill_pct;
  logic [plc_pkg::LedW-1:0]   led_now;
  logic [plc_pkg::DistW-1:0]  dist_now_cm;

  // Expected statuses, oldest first, and the count of failed checks.
  plc_pkg::plc_out_t status_q[$];
  int                status_errors = 0;

  // Directed table: the item, whether a literal status is given, and that status.
  plc_pkg::plc_in_t  probe_item_q[$];
  bit                probe_lit_q[$];
  plc_pkg::plc_out_t probe_want_q[$];

  proximity_lid_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Returns the predictor to its state after reset, configuration included.
  task automatic reset_prediction();
    cfg_open_cm     = plc_pkg::OpenDistReset;
    cfg_interval_ms = plc_pkg::IntervalReset;
    cfg_settle_ms   = plc_pkg::SettleReset;
    cfg_lock_level  = plc_pkg::LockLevelReset;
    lid_locked      = 1'b0;
    open_now        = 1'b0;
    closed_at_ms    = '0;
    measured_at_ms  = '0;
    fill_pct        = '0;
    led_now         = '0;
    dist_now_cm     = '0;
  endtask

  // One pass of the control loop: the command is handled first, then the
  // measurement step, and the status after both is returned.
  function automatic plc_pkg::plc_out_t predict_status(plc_pkg::plc_in_t it);
    plc_pkg::plc_out_t          st;
    logic [plc_pkg::StampW-1:0] ready_ms;
    logic [plc_pkg::StampW-1:0] due_ms;
    int unsigned                ir_cm;
    int unsigned                echo_cm;
    logic                       took;
    took = 1'b0;
    if (it.mode == plc_pkg::MODE_LED) begin
      lid_locked = (it.brightness == cfg_lock_level);
      led_now    = it.brightness;
    end else if (it.mode == plc_pkg::MODE_REPORT) begin
      ready_ms = closed_at_ms + plc_pkg::StampW'(cfg_settle_ms);
      if (!open_now && it.now_ms > ready_ms) begin
        // A zero sample means nothing in sight: the distance clamps to 26 cm.
        ir_cm = 26;
        if (it.ir_adc != 0) begin
          ir_cm = 13312 / (5 * int'(it.ir_adc));
          if (ir_cm > 26) ir_cm = 26;
        end
        fill_pct = plc_pkg::PctW'(((26 - ir_cm) * 100) / 26);
      end
    end
    // The deadline wraps modulo 2^32 just as the timestamp does.
    due_ms = measured_at_ms + plc_pkg::StampW'(cfg_interval_ms);
    if (it.now_ms > due_ms) begin
      took           = 1'b1;
      measured_at_ms = it.now_ms;
      echo_cm        = int'(it.echo_us) / 58;
      if (echo_cm == 0) echo_cm = 400;
      dist_now_cm = plc_pkg::DistW'(echo_cm);
      if (echo_cm < int'(cfg_open_cm) && !lid_locked) begin
        open_now = 1'b1;
      end else begin
        // Only an open-to-closed change restarts the settling time.
        if (open_now) closed_at_ms = it.now_ms;
        open_now = 1'b0;
      end
    end
    st.lid_is_open  = open_now;
    st.servo_angle  = open_now ? plc_pkg::ServoOpen : plc_pkg::ServoClosed;
    st.led_level    = led_now;
    st.lock_flag    = lid_locked;
    st.measured     = took;
    st.distance_cm  = dist_now_cm;
    st.report_valid = (it.mode == plc_pkg::MODE_REPORT);
    st.fullness_pct = fill_pct;
    return st;
  endfunction

  function automatic plc_pkg::plc_in_t make_item(plc_pkg::plc_mode_e mode,
                                                 logic [plc_pkg::LedW-1:0] bright,
                                                 logic [plc_pkg::StampW-1:0] now,
                                                 logic [plc_pkg::EchoW-1:0] echo,
                                                 logic [plc_pkg::AdcW-1:0] adc);
    plc_pkg::plc_in_t it;
    it.mode       = mode;
    it.brightness = bright;
    it.now_ms     = now;
    it.echo_us    = echo;
    it.ir_adc     = adc;
    return it;
  endfunction

  function automatic plc_pkg::plc_out_t make_status(logic open,
                                                    logic [plc_pkg::LedW-1:0] led,
                                                    logic lock, logic meas,
                                                    logic [plc_pkg::DistW-1:0] dist_cm,
                                                    logic rep,
                                                    logic [plc_pkg::PctW-1:0] fill);
    plc_pkg::plc_out_t st;
    st.lid_is_open  = open;
    st.servo_angle  = open ? plc_pkg::ServoOpen : plc_pkg::ServoClosed;
    st.led_level    = led;
    st.lock_flag    = lock;
    st.measured     = meas;
    st.distance_cm  = dist_cm;
    st.report_valid = rep;
    st.fullness_pct = fill;
    return st;
  endfunction

  task automatic add_row(plc_pkg::plc_in_t it, bit lit, plc_pkg::plc_out_t want);
    probe_item_q.push_back(it);
    probe_lit_q.push_back(lit);
    probe_want_q.push_back(want);
  endtask

  // Offers one item, idling first at the sender's rate, and waits for its transfer.
  // Called and returning at a rising edge, so valid is assigned once per time step
  // and stays high between back-to-back items.
  task automatic push_item(plc_pkg::plc_in_t it, bit lit, plc_pkg::plc_out_t want);
    plc_pkg::plc_out_t st;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    st = predict_status(it);
    if (lit) st = want;
    status_q.push_back(st);
  endtask

  // Lets the block run dry: every expected status has arrived, then a margin.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver: random stalls at the current rate, and on request one long hold-off
  // during which the sender keeps offering, so the block fills and stalls its input.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Each status transfer is checked field by field against the oldest expectation.
  always @(posedge clk_i) begin
    plc_pkg::plc_out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (status_q.size() == 0) begin
        status_errors++;
        if (status_errors <= MaxReported) begin
          $display("%0t: status transfer with none expected", $time);
        end
      end else begin
        want = status_q.pop_front();
        if (out_data_o.lid_is_open  !== want.lid_is_open  ||
            out_data_o.servo_angle  !== want.servo_angle  ||
            out_data_o.led_level    !== want.led_level    ||
            out_data_o.lock_flag    !== want.lock_flag    ||
            out_data_o.measured     !== want.measured     ||
            out_data_o.distance_cm  !== want.distance_cm  ||
            out_data_o.report_valid !== want.report_valid ||
            out_data_o.fullness_pct !== want.fullness_pct) begin
          status_errors++;
          if (status_errors <= MaxReported) begin
            $display("%0t: want open %0d servo %0d led %0d lock %0d meas %0d dist %0d",
                     $time, want.lid_is_open, want.servo_angle, want.led_level,
                     want.lock_flag, want.measured, want.distance_cm);
            $display("          rep %0d fill %0d", want.report_valid, want.fullness_pct);
            $display("        got  open %0d servo %0d led %0d lock %0d meas %0d dist %0d",
                     out_data_o.lid_is_open, out_data_o.servo_angle, out_data_o.led_level,
                     out_data_o.lock_flag, out_data_o.measured, out_data_o.distance_cm);
            $display("          rep %0d fill %0d", out_data_o.report_valid,
                     out_data_o.fullness_pct);
          end
        end
      end
    end
  end

  // Watchdog: ends the run once nothing has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    plc_pkg::plc_in_t           it;
    plc_pkg::plc_out_t          blank;
    logic [plc_pkg::OpenW-1:0]  w_open;
    logic [plc_pkg::MsW-1:0]    w_interval;
    logic [plc_pkg::MsW-1:0]    w_settle;
    logic [plc_pkg::LedW-1:0]   w_lock;
    logic [plc_pkg::StampW-1:0] clock_ms;
    int unsigned                pick;

    blank = '0;
    reset_prediction();

    // Directed part, under the reset configuration (20 cm, 1000 ms, 1500 ms, 255).
    // Straight after reset nothing is due and the lid reads closed.
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd0, 16'd0, 10'd0), 1'b1,
            make_status(1'b0, 8'd0, 1'b0, 1'b0, 11'd0, 1'b0, 7'd0));
    // A report before the lid has settled keeps the level; the interval is not yet
    // exceeded at exactly 1000 ms.
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd1000, 16'd0, 10'd0), 1'b1,
            make_status(1'b0, 8'd0, 1'b0, 1'b0, 11'd0, 1'b1, 7'd0));
    // No echo reads as 400 cm.
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd1001, 16'd0, 10'd0), 1'b1,
            make_status(1'b0, 8'd0, 1'b0, 1'b1, 11'd400, 1'b0, 7'd0));
    // Something at 5 cm opens the lid.
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd2002, 16'd290, 10'd0), 1'b1,
            make_status(1'b1, 8'd0, 1'b0, 1'b1, 11'd5, 1'b0, 7'd0));
    // A report while open is ignored.
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd2003, 16'd0, 10'd1023), 1'b0, blank);
    // Longest echo: 1129 cm closes the lid and stamps the close time.
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd3003, 16'hFFFF, 10'd0), 1'b1,
            make_status(1'b0, 8'd0, 1'b0, 1'b1, 11'd1129, 1'b0, 7'd0));
    // Exactly at the end of the settling time, then just past it.
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd4503, 16'd0, 10'd1023), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd4504, 16'd0, 10'd1023), 1'b0, blank);
    // Zero sample, smallest non-zero sample, and two mid-range samples.
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd4505, 16'd0, 10'd0), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd4506, 16'd0, 10'd1), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd4507, 16'd0, 10'd103), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_REPORT, 8'd0, 32'd4508, 16'd0, 10'd532), 1'b0, blank);
    // The lock level locks the lid: a near object must not open it.
    add_row(make_item(plc_pkg::MODE_LED, 8'd255, 32'd4509, 16'd0, 10'd0), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd5600, 16'd58, 10'd0), 1'b0, blank);
    // Any other level unlocks it, and the lid then opens.
    add_row(make_item(plc_pkg::MODE_LED, 8'd0, 32'd5601, 16'd0, 10'd0), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd6700, 16'd58, 10'd0), 1'b0, blank);
    // The spare mode is a plain pass.
    add_row(make_item(plc_pkg::MODE_SPARE, 8'hAA, 32'd6701, 16'd0, 10'h3FF), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_LED, 8'd254, 32'd6702, 16'd0, 10'd0), 1'b0, blank);
    // An echo shorter than one centimetre reads as no echo.
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd7800, 16'd57, 10'd0), 1'b0, blank);
    // Either side of the opening threshold: 19 cm opens, 20 cm does not.
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd8900, 16'd1159, 10'd0), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd10000, 16'd1160, 10'd0), 1'b0, blank);
    // Largest timestamp, then the wrap to small values and the wrapped deadline.
    add_row(make_item(plc_pkg::MODE_PASS, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF), 1'b0,
            blank);
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd5, 16'd0, 10'd0), 1'b0, blank);
    add_row(make_item(plc_pkg::MODE_PASS, 8'd0, 32'd1000, 16'd290, 10'd0), 1'b0, blank);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 32;
    rcv_idle_pct = 56;
    foreach (probe_item_q[k]) push_item(probe_item_q[k], probe_lit_q[k], probe_want_q[k]);

    // Random part: six phases, each under its own configuration, written while idle.
    clock_ms = $urandom();
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin
          w_open     = plc_pkg::OpenW'(20);
          w_interval = plc_pkg::MsW'(1000);
          w_settle   = plc_pkg::MsW'(1500);
          w_lock     = plc_pkg::LedW'(255);
        end
        1: begin
          w_open     = plc_pkg::OpenW'(400);
          w_interval = plc_pkg::MsW'(0);
          w_settle   = plc_pkg::MsW'(0);
          w_lock     = plc_pkg::LedW'(0);
        end
        2: begin
          w_open     = plc_pkg::OpenW'(0);
          w_interval = plc_pkg::MsW'(65535);
          w_settle   = plc_pkg::MsW'(65535);
          w_lock     = plc_pkg::LedW'(128);
        end
        5: begin
          w_open     = plc_pkg::OpenW'(400);
          w_interval = plc_pkg::MsW'(1);
          w_settle   = plc_pkg::MsW'(65535);
          w_lock     = plc_pkg::LedW'(255);
        end
        default: begin
          w_open     = plc_pkg::OpenW'($urandom_range(0, 400));
          w_interval = plc_pkg::MsW'($urandom_range(0, 65535));
          w_settle   = plc_pkg::MsW'($urandom_range(0, 65535));
          w_lock     = plc_pkg::LedW'($urandom_range(0, 255));
        end
      endcase

      // One register per cycle; the enable is lowered only after the last one.
      cfg_we    <= 1'b1;
      cfg_idx   <= plc_pkg::REG_OPEN_DIST;
      cfg_wdata <= plc_pkg::CfgDataW'(w_open);
      @(posedge clk_i);
      cfg_idx   <= plc_pkg::REG_INTERVAL;
      cfg_wdata <= w_interval;
      @(posedge clk_i);
      cfg_idx   <= plc_pkg::REG_SETTLE;
      cfg_wdata <= w_settle;
      @(posedge clk_i);
      cfg_idx   <= plc_pkg::REG_LOCK_LVL;
      cfg_wdata <= plc_pkg::CfgDataW'(w_lock);
      @(posedge clk_i);
      cfg_we    <= 1'b0;
      cfg_open_cm     = w_open;
      cfg_interval_ms = w_interval;
      cfg_settle_ms   = w_settle;
      cfg_lock_level  = w_lock;

      // First the sender idles more lightly, then the receiver, then neither.
      if (ph < 2) begin
        snd_idle_pct = 32;
        rcv_idle_pct = 56;
      end else if (ph < 4) begin
        snd_idle_pct = 56;
        rcv_idle_pct = 32;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (ph == 0) hold_tag <= hold_tag + 1;

      repeat (ItemsPerPhase) begin
        // Timestamps mostly move forward in steps around the interval, so that
        // measurements, openings, closings and settled reports all come round.
        // Now and then they jump anywhere or to just short of the wrap.
        pick = $urandom_range(99);
        if (pick < 8) clock_ms = $urandom();
        else if (pick < 11)
          clock_ms = 32'hFFFF_FFFF - plc_pkg::StampW'($urandom_range(0, 3000));
        else
          clock_ms = clock_ms
                   + plc_pkg::StampW'($urandom_range(0, 2 * int'(w_interval) + 2));
        it.now_ms = clock_ms;

        pick = $urandom_range(99);
        if (pick < 40) it.mode = plc_pkg::MODE_PASS;
        else if (pick < 60) it.mode = plc_pkg::MODE_LED;
        else if (pick < 90) it.mode = plc_pkg::MODE_REPORT;
        else it.mode = plc_pkg::MODE_SPARE;

        // Brightness often hits the lock level so that locking is exercised.
        if ($urandom_range(99) < 40) it.brightness = w_lock;
        else it.brightness = plc_pkg::LedW'($urandom_range(0, 255));

        // Echoes are weighted towards the opening threshold.
        pick = $urandom_range(99);
        if (pick < 10) it.echo_us = '0;
        else if (pick < 55)
          it.echo_us = plc_pkg::EchoW'($urandom_range(0, 58 * int'(w_open) + 200));
        else it.echo_us = plc_pkg::EchoW'($urandom_range(0, 65535));

        if ($urandom_range(99) < 10) it.ir_adc = '0;
        else it.ir_adc = plc_pkg::AdcW'($urandom_range(0, 1023));

        push_item(it, 1'b0, blank);
      end
    end

    drain_results();
    if (status_errors == 0 && status_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
